// File: hdl/kfl_pkg.sv
package kfl_pkg;

    localparam int MAX_KEYS = 64;
    localparam int SLOT_W = $clog2(MAX_KEYS);
    localparam int CNT_W = 7;
    localparam int TIME_W = 32;
    localparam int POS_W = 32;
    localparam int FRAC_W = 16;
    localparam int QUO_W = FRAC_W + 1;
    localparam int EXT_W = TIME_W + FRAC_W;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic [0:0] func;
        logic [SLOT_W-1:0] key_slot;
        logic [TIME_W-1:0] key_time;
        logic signed [POS_W-1:0] key_x;
        logic signed [POS_W-1:0] key_y;
        logic signed [POS_W-1:0] key_z;
        logic [TIME_W-1:0] query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [0:0] out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [QUO_W-1:0] quo;
        logic [EXT_W-1:0] rem;
        logic [EXT_W-1:0] dvs;
    } t_div_word;

endpackage

// File: hdl/kfl_if.sv
interface kfl_in_if
    import kfl_pkg::*;
();
    logic valid;
    logic ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface kfl_out_if
    import kfl_pkg::*;
();
    logic valid;
    logic ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/kfl_div_cell.sv
module kfl_div_cell
    import kfl_pkg::*;
(
    input  logic      i_clk,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word r_word;
    logic [EXT_W:0] w_diff;

    always_comb begin
        w_diff = {r_word.rem, 1'b0} - {1'b0, r_word.dvs};
    end

    always_ff @(posedge i_clk) begin
        r_word <= i_word;
    end

    always_comb begin
        o_word = r_word;
        if (!w_diff[EXT_W]) begin
            o_word.rem = w_diff[EXT_W-1:0];
            o_word.quo = {r_word.quo[QUO_W-2:0], 1'b1};
        end else begin
            o_word.rem = {r_word.rem[EXT_W-2:0], 1'b0};
            o_word.quo = {r_word.quo[QUO_W-2:0], 1'b0};
        end
    end

endmodule

// File: hdl/keyframe_position_lerp_core.sv
// Keyframe position interpolator.
// Input channel i_in carries items with func 0 (write one keyframe at key_slot)
// or func 1 (query a position at query_time). Output channel o_out carries one
// item for every query and none for a load.
// The single register keys_in_use is written through i_cfg_we and i_cfg_data;
// the user must write it only while the block is idle; the block itself does not
// enforce this. Zero acts as one key and values above 64 as 64. A load is written
// straight into the key table. A query walks the table one key per cycle to find
// its key pair, then sends the time fraction through a row of 17 divider cells,
// one quotient bit per cell per cycle, then blends in the multiply and sum steps.
// The table walk and the divider row set how long a query takes; one item is worked on at a time.
// Reset clears the control state and sets keys_in_use to one; the key table
// is not cleared and must be loaded before it is queried.
// A finished item waits in the output register while the receiver stalls,
// and the next item is not taken until it has been delivered.
module keyframe_position_lerp_core
    import kfl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    kfl_in_if.sink      i_in,
    kfl_out_if.source   o_out
);

    typedef enum logic [2:0] {S_IDLE, S_FIRST, S_WALK, S_DIV, S_MUL, S_SUM, S_OUT} t_state;

    t_state r_state;
    logic [CNT_W-1:0] r_keys;
    logic [TIME_W-1:0] r_q;
    logic [SLOT_W:0] r_i;
    logic [SLOT_W:0] r_n;
    logic [4:0] r_cnt;
    logic [TIME_W-1:0] r_tl;
    logic [TIME_W-1:0] r_d;
    logic [QUO_W-1:0] r_f;
    logic signed [POS_W-1:0] r_l [3];
    logic signed [POS_W-1:0] r_r [3];
    logic signed [POS_W+QUO_W:0] r_pl [3];
    logic signed [POS_W+QUO_W:0] r_pr [3];
    t_out_item r_out;

    logic [TIME_W-1:0] mem_t [MAX_KEYS];
    logic [POS_W-1:0] mem_x [MAX_KEYS];
    logic [POS_W-1:0] mem_y [MAX_KEYS];
    logic [POS_W-1:0] mem_z [MAX_KEYS];
    logic [TIME_W-1:0] r_rt;
    logic [POS_W-1:0] r_rx, r_ry, r_rz;
    logic [SLOT_W-1:0] w_raddr;

    localparam int NCELL = QUO_W;
    t_div_word w_chain [NCELL+1];

    logic [SLOT_W:0] w_n;
    assign w_n = (r_keys == '0) ? (SLOT_W+1)'(1) :
                 (r_keys > CNT_W'(MAX_KEYS)) ? (SLOT_W+1)'(MAX_KEYS) : r_keys[SLOT_W:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keys <= CNT_W'(1);
        end else if (i_cfg_we) begin
            r_keys <= i_cfg_data;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = (r_state == S_OUT);
    assign o_out.data = r_out;

    always_comb begin
        w_raddr = SLOT_W'(r_i + 1'b1);
        if (r_state == S_IDLE) begin
            w_raddr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready && i_in.data.func == FUNC_LOAD) begin
            mem_t[i_in.data.key_slot] <= i_in.data.key_time;
            mem_x[i_in.data.key_slot] <= i_in.data.key_x;
            mem_y[i_in.data.key_slot] <= i_in.data.key_y;
            mem_z[i_in.data.key_slot] <= i_in.data.key_z;
        end
        r_rt <= mem_t[w_raddr];
        r_rx <= mem_x[w_raddr];
        r_ry <= mem_y[w_raddr];
        r_rz <= mem_z[w_raddr];
    end

    assign w_chain[0].quo = '0;
    assign w_chain[0].rem = {{FRAC_W{1'b0}}, r_q - r_tl};
    assign w_chain[0].dvs = {{(EXT_W-TIME_W-1){1'b0}}, r_d, 1'b0};

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        kfl_div_cell u_cell (.i_clk(i_clk), .i_word(w_chain[g]), .o_word(w_chain[g+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.data.func == FUNC_QUERY) begin
                        r_q <= i_in.data.query_time;
                        r_n <= w_n;
                        r_i <= '0;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_l[0] <= r_rx; r_l[1] <= r_ry; r_l[2] <= r_rz;
                    r_tl <= r_rt;
                    r_out.pos_x <= r_rx; r_out.pos_y <= r_ry; r_out.pos_z <= r_rz;
                    r_out.out_of_range <= 1'b0;
                    if (r_n == (SLOT_W+1)'(1)) begin
                        r_state <= S_OUT;
                    end else if (r_q < r_rt) begin
                        r_out.out_of_range <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_i <= (SLOT_W+1)'(1);
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_q <= r_rt) begin
                        r_d <= r_rt - r_tl;
                        r_r[0] <= r_rx; r_r[1] <= r_ry; r_r[2] <= r_rz;
                        r_cnt <= '0;
                        if (r_rt == r_tl) begin
                            r_out.pos_x <= r_l[0]; r_out.pos_y <= r_l[1];
                            r_out.pos_z <= r_l[2];
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end else if (r_i + 1'b1 >= r_n) begin
                        r_out.pos_x <= r_rx; r_out.pos_y <= r_ry; r_out.pos_z <= r_rz;
                        r_out.out_of_range <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_l[0] <= r_rx; r_l[1] <= r_ry; r_l[2] <= r_rz;
                        r_tl <= r_rt;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 5'(NCELL)) begin
                        r_f <= w_chain[NCELL].quo;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    for (int k = 0; k < 3; k++) begin
                        r_pl[k] <= r_l[k] * $signed({1'b0, (QUO_W)'(1 << FRAC_W) - r_f});
                        r_pr[k] <= r_r[k] * $signed({1'b0, r_f});
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_out.pos_x <= POS_W'((r_pl[0] + r_pr[0]) / (1 <<< FRAC_W));
                    r_out.pos_y <= POS_W'((r_pl[1] + r_pr[1]) / (1 <<< FRAC_W));
                    r_out.pos_z <= POS_W'((r_pl[2] + r_pr[2]) / (1 <<< FRAC_W));
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_d != '0)) else $error("zero divisor in divider");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_f <= QUO_W'(1 << FRAC_W))) else $error("fraction above one");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_i < r_n)) else $error("walk past last key");

endmodule
